/* hw/rtl/tconv2d_pkg.sv */
// Package for the transposed convolution block: item kinds, register indexes,
// default sizes, the stride limit and helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tconv2d_pkg;
  localparam int DefMaxWidth    = 32;
  localparam int DefMaxHeight   = 32;
  localparam int DefMaxChannels = 16;
  localparam int DefMaxKernel   = 4;
  localparam int DefDilationX   = 1;
  localparam int DefDilationY   = 1;
  localparam int MaxStride      = 4;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_BIAS   = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [2:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_IN_CHAN   = 3'd2;
  localparam logic [2:0] REG_OUT_CHAN  = 3'd3;
  localparam logic [2:0] REG_KER_W     = 3'd4;
  localparam logic [2:0] REG_KER_H     = 3'd5;
  localparam logic [2:0] REG_STRIDE_X  = 3'd6;
  localparam logic [2:0] REG_STRIDE_Y  = 3'd7;

  // saturate a 32-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // clamp a register to 1..hi
  function automatic logic [8:0] clampu(input logic [5:0] v, input logic [8:0] hi);
    if (v == 6'd0) return 9'd1;
    if ({3'd0, v} > hi) return hi;
    return {3'd0, v};
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/transposed_convolution_2d.sv */
// Channel      | dir | contents
// s_axis       | in  | tuser kind, tdata src,dst,row,col,value
// m_axis       | out | tuser outside, tdata result
// cfg          | in  | index 3 bits, data 32 bits
// An item is captured in ST_IDLE and written in ST_LOAD. A query walks every tap:
// one shared multiplier and accumulator, one read of each memory and
// one multiply-accumulate per tap step. Reset clears the bias valid bits and control.
// The input side stalls while an item loads, while a query runs or while its result waits on m_axis_tready.
// Depends on tconv2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module transposed_convolution_2d #(
  parameter int MAX_WIDTH    = tconv2d_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT   = tconv2d_pkg::DefMaxHeight,
  parameter int MAX_CHANNELS = tconv2d_pkg::DefMaxChannels,
  parameter int MAX_KERNEL   = tconv2d_pkg::DefMaxKernel,
  parameter int DILATION_X   = tconv2d_pkg::DefDilationX,
  parameter int DILATION_Y   = tconv2d_pkg::DefDilationY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // src_channel, dst_channel, row, col, value
  input  wire logic [1:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // result
  output logic             m_axis_tuser,  // outside
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import tconv2d_pkg::*;

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MAP_D = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_D = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int MAW = (MAP_D > 1) ? $clog2(MAP_D) : 1;
  localparam int WAW = (WGT_D > 1) ? $clog2(WGT_D) : 1;
  localparam logic [8:0] HI_W = 9'(MAX_WIDTH > 63 ? 63 : MAX_WIDTH);
  localparam logic [8:0] HI_H = 9'(MAX_HEIGHT > 63 ? 63 : MAX_HEIGHT);
  localparam logic [8:0] HI_C = 9'(MAX_CHANNELS > 31 ? 31 : MAX_CHANNELS);
  localparam logic [8:0] HI_K = 9'(MAX_KERNEL > 7 ? 7 : MAX_KERNEL);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_TAP  = 3'd2;
  localparam logic [2:0] ST_MAC  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state;
  logic [5:0] r_w, r_h;
  logic [4:0] r_ic, r_oc;
  logic [2:0] r_kw, r_kh, r_sx, r_sy;

  logic [1:0] kind;
  logic [3:0] src, dst;
  logic [6:0] row, col;
  logic signed [31:0] val;

  logic signed [15:0] map_mem [MAP_D];
  logic signed [15:0] wgt_mem [WGT_D];
  logic signed [31:0] bias_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] bias_ok;

  logic [8:0] w, h, ic, oc, kw, kh, sx, sy;
  assign w  = clampu(r_w, HI_W);
  assign h  = clampu(r_h, HI_H);
  assign ic = clampu({1'b0, r_ic}, HI_C);
  assign oc = clampu({1'b0, r_oc}, HI_C);
  assign kw = clampu({3'd0, r_kw}, HI_K);
  assign kh = clampu({3'd0, r_kh}, HI_K);
  assign sx = clampu({3'd0, r_sx}, 9'(MaxStride));
  assign sy = clampu({3'd0, r_sy}, 9'(MaxStride));

  logic signed [13:0] ext_w, ext_h, outw, outh;
  assign ext_w = 14'(DILATION_X) * $signed({5'd0, kw - 9'd1}) + 14'sd1;
  assign ext_h = 14'(DILATION_Y) * $signed({5'd0, kh - 9'd1}) + 14'sd1;
  assign outw  = $signed({5'd0, w - 9'd1}) * $signed({5'd0, sx}) + ext_w;
  assign outh  = $signed({5'd0, h - 9'd1}) * $signed({5'd0, sy}) + ext_h;

  logic [7:0] q;
  logic [4:0] ty, tx;
  logic signed [47:0] acc;
  logic signed [15:0] px, wt;
  logic rd_ok;
  logic [31:0] res;
  logic outside;

  // tap geometry for the current (ty, tx)
  logic signed [13:0] ys, xs, iy, ix;
  logic y_ok, x_ok;
  always_comb begin
    ys = $signed({7'd0, row}) + $signed({9'd0, ty}) * 14'(DILATION_Y) - (ext_h - 14'sd1);
    xs = $signed({7'd0, col}) + $signed({9'd0, tx}) * 14'(DILATION_X) - (ext_w - 14'sd1);
    // stride is at most 4: divide by small case
    case (sy[2:0])
      3'd2:    iy = ys >>> 1;
      3'd3:    iy = 14'((ys * 14'sd43) >>> 7);
      3'd4:    iy = ys >>> 2;
      default: iy = ys;
    endcase
    case (sx[2:0])
      3'd2:    ix = xs >>> 1;
      3'd3:    ix = 14'((xs * 14'sd43) >>> 7);
      3'd4:    ix = xs >>> 2;
      default: ix = xs;
    endcase
    y_ok = (ys >= 0) && (iy * $signed({5'd0, sy}) == ys) && (iy < $signed({5'd0, h}));
    x_ok = (xs >= 0) && (ix * $signed({5'd0, sx}) == xs) && (ix < $signed({5'd0, w}));
  end

  logic [MAW-1:0] map_a;
  logic [WAW-1:0] wgt_a;
  logic [4:0] fy, fx;
  always_comb begin
    fy = 5'(kh) - 5'd1 - ty;
    fx = 5'(kw) - 5'd1 - tx;
    map_a = MAW'((q * MAX_HEIGHT + iy[HW:0]) * MAX_WIDTH + ix[WW:0]);
    wgt_a = WAW'(((dst * MAX_CHANNELS + q) * MAX_KERNEL + fy) * MAX_KERNEL + fx);
  end

  logic last_x, last_y;
  assign last_x = ({4'd0, tx} == kw - 9'd1);
  assign last_y = ({4'd0, ty} == kh - 9'd1);

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = res;
  assign m_axis_tuser  = outside;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r_w <= 6'd1; r_h <= 6'd1; r_ic <= 5'd1; r_oc <= 5'd1;
      r_kw <= 3'd1; r_kh <= 3'd1; r_sx <= 3'd1; r_sy <= 3'd1;
      bias_ok <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IN_WIDTH:  r_w  <= cfg_data[5:0];
          REG_IN_HEIGHT: r_h  <= cfg_data[5:0];
          REG_IN_CHAN:   r_ic <= cfg_data[4:0];
          REG_OUT_CHAN:  r_oc <= cfg_data[4:0];
          REG_KER_W:     r_kw <= cfg_data[2:0];
          REG_KER_H:     r_kh <= cfg_data[2:0];
          REG_STRIDE_X:  r_sx <= cfg_data[2:0];
          REG_STRIDE_Y:  r_sy <= cfg_data[2:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_IDLE;
          q <= '0; ty <= '0; tx <= '0;
          acc <= 48'((bias_ok[CW'(dst)] && 32'(dst) < MAX_CHANNELS)
                     ? bias_mem[CW'(dst)] : 32'sd0);
          if (kind == KIND_BIAS && 32'(dst) < MAX_CHANNELS) bias_ok[CW'(dst)] <= 1'b1;
          if (kind == KIND_QUERY) begin
            outside <= (9'(dst) >= oc) || ($signed({7'd0, row}) >= outh)
                       || ($signed({7'd0, col}) >= outw);
            if ((9'(dst) >= oc) || ($signed({7'd0, row}) >= outh)
                || ($signed({7'd0, col}) >= outw)) begin
              res <= '0;
              state <= ST_OUT;
            end else begin
              state <= ST_TAP;
            end
          end
        end
        ST_TAP: begin
          state <= ST_MAC;
          if (last_x) begin
            tx <= '0;
            if (last_y) begin
              ty <= '0;
              q <= q + 8'd1;
            end else ty <= ty + 5'd1;
          end else tx <= tx + 5'd1;
        end
        ST_MAC: begin
          if (rd_ok) acc <= acc + 48'(px * wt);
          // tap counters wrapped past the end once q reached ic
          state <= ({1'b0, q} == ic) ? ST_SAT : ST_TAP;
        end
        ST_SAT: begin
          if (acc > 48'sh7fffffff) res <= 32'h7fffffff;
          else if (acc < -48'sh80000000) res <= 32'h80000000;
          else res <= acc[31:0];
          state <= ST_OUT;
        end
        ST_OUT: if (m_axis_tready) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload: item capture, memories, tap reads
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      kind <= s_axis_tuser;
      src  <= s_axis_tdata[3:0];
      dst  <= s_axis_tdata[7:4];
      row  <= s_axis_tdata[14:8];
      col  <= s_axis_tdata[21:15];
      val  <= s_axis_tdata[53:22] ;
    end
    if (state == ST_LOAD) begin
      if (kind == KIND_PIXEL && 32'(src) < MAX_CHANNELS && 32'(row) < MAX_HEIGHT
          && 32'(col) < MAX_WIDTH)
        map_mem[MAW'((src * MAX_HEIGHT + row) * MAX_WIDTH + col)] <= sat16(val);
      if (kind == KIND_WEIGHT && 32'(src) < MAX_CHANNELS && 32'(dst) < MAX_CHANNELS
          && 32'(row) < MAX_KERNEL && 32'(col) < MAX_KERNEL)
        wgt_mem[WAW'(((dst * MAX_CHANNELS + src) * MAX_KERNEL + row) * MAX_KERNEL + col)]
          <= sat16(val);
      if (kind == KIND_BIAS && 32'(dst) < MAX_CHANNELS) bias_mem[CW'(dst)] <= val;
    end
    if (state == ST_TAP) begin
      rd_ok <= y_ok && x_ok;
      px <= map_mem[map_a];
      wt <= wgt_mem[wgt_a];
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("outside result not zero");
`endif
endmodule
`default_nettype wire
